// File: src/tile_table_refcount_engine_core_assert.svh
`ifndef TILE_TABLE_REFCOUNT_ENGINE_CORE_ASSERT_SVH
`define TILE_TABLE_REFCOUNT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define TTRE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define TTRE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ttre_pkg.sv
package ttre_pkg;

  localparam logic [2:0] OP_REF     = 3'd0;
  localparam logic [2:0] OP_UNREF   = 3'd1;
  localparam logic [2:0] OP_ALLOC   = 3'd2;
  localparam logic [2:0] OP_UNALLOC = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_UNALLOC = 2'd2;

  localparam logic [1:0] CFG_IMAGE_WIDTH     = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd2;
  localparam logic [1:0] CFG_AUTO_ALLOC      = 2'd3;

  localparam logic [12:0] IMAGE_WIDTH_RST     = 13'd4096;
  localparam logic [12:0] IMAGE_HEIGHT_RST    = 13'd4096;
  localparam logic [4:0]  BYTES_PER_PIXEL_RST = 5'd1;

  localparam logic [15:0] REFS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        warning;
    logic [11:0] tile_index;
    logic [11:0] tile_x_base;
    logic [11:0] tile_y_base;
    logic [6:0]  portion_width;
    logic [6:0]  portion_height;
    logic [15:0] byte_offset;
    logic [10:0] row_stride;
    logic        allocated;
    logic [15:0] ref_total;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [12:0] wdata;
  } cfg_word_t;

  typedef struct packed {
    logic        allocated;
    logic [15:0] refs;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_IDX,
    S_READ,
    S_MODIFY
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctl_t;

endpackage

// File: src/ttre_chan_if.sv
interface ttre_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/ttre_table.sv
module ttre_table #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  ttre_pkg::tbl_ctl_t  ctl_in,
  output logic                busy,
  input  logic [AW-1:0]       rd_addr,
  output ttre_pkg::entry_t    rd_data,
  input  logic [AW-1:0]       wr_addr,
  input  ttre_pkg::entry_t    wr_data
);
  import ttre_pkg::*;

  entry_t        mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign we    = busy | ctl_in.wr_en;
  assign waddr = busy ? clr_addr : wr_addr;
  assign wdata = busy ? entry_t'('0) : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/tile_table_refcount_engine_core.sv
// Tile table with reference counts for a tiled image buffer.
// cfg: register writes (index, data); always ready. Write only while idle.
// req: one word per request (op, pixel_x, pixel_y).
// rsp: one word per request: status, warning, tile geometry, flag and count.
// A request is taken in the idle state and then runs through these steps:
// reciprocal divides, tile index and offsets, table read, then
// modify/write-back into the output register. No new request is taken
// until the previous one has finished its single table read-modify-write.
// The output register holds a result until taken; a new request is accepted
// while it waits, and that request stalls in its final step until rsp is
// free. No state is changed until its result is loaded.
// Reset: config registers return to their defaults and a clearing pass
// writes every table entry to zero, with req.ready low.
`include "tile_table_refcount_engine_core_assert.svh"

module tile_table_refcount_engine_core #(
  parameter int TILE_W    = 64,
  parameter int TILE_H    = 64,
  parameter int MAX_TILES = 4096
) (
  input logic            clk,
  input logic            rst,
  ttre_chan_if.sink      cfg,
  ttre_chan_if.sink      req,
  ttre_chan_if.source    rsp
);
  import ttre_pkg::*;

  localparam int AW    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int QXW   = $clog2(4095 / TILE_W + 1);
  localparam int QYW   = $clog2(4095 / TILE_H + 1);
  localparam int PRW   = $clog2((8191 + TILE_W - 1) / TILE_W + 1);
  localparam int IDXW  = QYW + PRW + 1;
  localparam int XOW   = $clog2(TILE_W);
  localparam int YOW   = $clog2(TILE_H);
  localparam int LINW  = $clog2(TILE_W * TILE_H);

  localparam int DN    = 12;
  localparam int DPW   = 2 * DN + 2;
  localparam int RX_SH = DN + $clog2(TILE_W);
  localparam int RX_M  = ((1 << RX_SH) + TILE_W - 1) / TILE_W;
  localparam int RY_SH = DN + $clog2(TILE_H);
  localparam int RY_M  = ((1 << RY_SH) + TILE_H - 1) / TILE_H;
  localparam int PN    = 14;
  localparam int PPW   = 2 * PN + 2;
  localparam int PR_SH = PN + $clog2(TILE_W);
  localparam int PR_M  = ((1 << PR_SH) + TILE_W - 1) / TILE_W;

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [4:0]  bytes_per_pixel;
  logic        auto_alloc;

  state_t state, state_next;

  logic [2:0]  op_r;
  logic [11:0] px_r, py_r;

  logic [DPW-1:0] prod_x, prod_y;
  logic [PPW-1:0] prod_pr;
  logic [13:0]    wsum;
  logic [QXW-1:0] qx_r;
  logic [QYW-1:0] qy_r;
  logic [PRW-1:0] per_row_r;
  logic           outside_r;

  logic [11:0]     xb, yb, xb_r, yb_r;
  logic [XOW-1:0]  xoff, xoff_r;
  logic [YOW-1:0]  yoff, yoff_r;
  logic [IDXW-1:0] idx_r;
  logic [LINW-1:0] lin_r;

  logic             fail, fail_r;
  logic [LINW+4:0]  bprod;
  logic [15:0]      byte_off_r;
  logic [10:0]      stride_r;
  logic [12:0]      rem_w, rem_h, wmin, hmin;
  logic [6:0]       pw_r, ph_r;

  tbl_ctl_t ctl;
  logic     tbl_busy;
  entry_t   rd_entry, new_entry;
  logic     out_free, load;
  logic [1:0] new_status;
  logic       new_warn;
  out_word_t  rsp_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= IMAGE_WIDTH_RST;
      image_height    <= IMAGE_HEIGHT_RST;
      bytes_per_pixel <= BYTES_PER_PIXEL_RST;
      auto_alloc      <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.data.reg_index)
        CFG_IMAGE_WIDTH:     image_width     <= cfg.data.wdata;
        CFG_IMAGE_HEIGHT:    image_height    <= cfg.data.wdata;
        CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg.data.wdata[4:0];
        CFG_AUTO_ALLOC:      auto_alloc      <= cfg.data.wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !rsp.valid || rsp.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req.valid && req.ready) state_next = S_DIV;
      S_DIV:    state_next = S_IDX;
      S_IDX:    state_next = S_READ;
      S_READ:   state_next = S_MODIFY;
      S_MODIFY: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    load      = 1'b0;
    ctl       = '0;
    case (state)
      S_IDLE:   req.ready = !tbl_busy;
      S_READ:   ctl.rd_en = !fail;
      S_MODIFY: begin
        load      = out_free;
        ctl.wr_en = out_free && !fail_r;
      end
      default: ;
    endcase
  end

  // capture request
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_r <= req.data.op;
      px_r <= req.data.pixel_x;
      py_r <= req.data.pixel_y;
    end
  end

  // tile column, row and tiles per row by reciprocal multiply
  assign prod_x  = DPW'(px_r) * DPW'(RX_M);
  assign prod_y  = DPW'(py_r) * DPW'(RY_M);
  assign wsum    = {1'b0, image_width} + 14'(TILE_W - 1);
  assign prod_pr = PPW'(wsum) * PPW'(PR_M);

  always_ff @(posedge clk) begin
    if (state == S_DIV) begin
      qx_r      <= prod_x[RX_SH +: QXW];
      qy_r      <= prod_y[RY_SH +: QYW];
      per_row_r <= prod_pr[PR_SH +: PRW];
      outside_r <= ({1'b0, px_r} >= image_width) || ({1'b0, py_r} >= image_height);
    end
  end

  // tile index, bases and offsets
  assign xb   = 12'(qx_r) * 12'(TILE_W);
  assign yb   = 12'(qy_r) * 12'(TILE_H);
  assign xoff = XOW'(px_r - xb);
  assign yoff = YOW'(py_r - yb);

  always_ff @(posedge clk) begin
    if (state == S_IDX) begin
      xb_r   <= xb;
      yb_r   <= yb;
      xoff_r <= xoff;
      yoff_r <= yoff;
      idx_r  <= IDXW'(qy_r) * IDXW'(per_row_r) + IDXW'(qx_r);
      lin_r  <= LINW'(32'(yoff) * 32'(TILE_W) + 32'(xoff));
    end
  end

  // table read, geometry
  assign fail  = outside_r || (32'(idx_r) >= 32'(MAX_TILES));
  assign bprod = (LINW+5)'(lin_r) * (LINW+5)'(bytes_per_pixel);
  assign rem_w = image_width - 13'(xb_r);
  assign rem_h = image_height - 13'(yb_r);
  assign wmin  = (rem_w < 13'(TILE_W)) ? rem_w : 13'(TILE_W);
  assign hmin  = (rem_h < 13'(TILE_H)) ? rem_h : 13'(TILE_H);

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      fail_r     <= fail;
      byte_off_r <= 16'(bprod);
      stride_r   <= 11'(32'(TILE_W) * 32'(bytes_per_pixel));
      pw_r       <= 7'(wmin - 13'(xoff_r));
      ph_r       <= 7'(hmin - 13'(yoff_r));
    end
  end

  ttre_table #(
    .DEPTH (MAX_TILES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl),
    .busy    (tbl_busy),
    .rd_addr (AW'(idx_r)),
    .rd_data (rd_entry),
    .wr_addr (AW'(idx_r)),
    .wr_data (new_entry)
  );

  // modify
  always_comb begin
    new_entry  = rd_entry;
    new_status = ST_OK;
    new_warn   = 1'b0;
    case (op_r)
      OP_REF: begin
        new_entry.allocated = rd_entry.allocated | auto_alloc;
        if (new_entry.allocated) begin
          if (rd_entry.refs != REFS_MAX) new_entry.refs = rd_entry.refs + 16'd1;
        end else begin
          new_status = ST_UNALLOC;
        end
      end
      OP_UNREF: begin
        if (rd_entry.refs != '0) new_entry.refs = rd_entry.refs - 16'd1;
        else new_warn = 1'b1;
      end
      OP_ALLOC: new_entry.allocated = 1'b1;
      OP_UNALLOC: begin
        if (rd_entry.allocated) begin
          new_warn            = (rd_entry.refs != '0);
          new_entry.allocated = 1'b0;
        end else begin
          new_status = ST_UNALLOC;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_next = '0;
    if (fail_r) begin
      rsp_next.status = ST_RANGE;
    end else begin
      rsp_next.status         = new_status;
      rsp_next.warning        = new_warn;
      rsp_next.tile_index     = 12'(idx_r);
      rsp_next.tile_x_base    = xb_r;
      rsp_next.tile_y_base    = yb_r;
      rsp_next.portion_width  = pw_r;
      rsp_next.portion_height = ph_r;
      rsp_next.byte_offset    = byte_off_r;
      rsp_next.row_stride     = stride_r;
      rsp_next.allocated      = new_entry.allocated;
      rsp_next.ref_total      = new_entry.refs;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.data <= rsp_next;
    end
  end

  `TTRE_ASSERT_IMP(a_no_write_on_fail, ctl.wr_en, !fail_r && state == S_MODIFY, "table written for a failed request")
  `TTRE_ASSERT_IMP(a_range_zeroed, rsp.valid && rsp.data.status == ST_RANGE, rsp.data.tile_index == '0 && rsp.data.ref_total == '0 && rsp.data.row_stride == '0 && !rsp.data.allocated, "range failure with non-zero fields")
  `TTRE_ASSERT_NXT(a_unalloc_clears, load && !fail_r && op_r == OP_UNALLOC && new_status == ST_OK, !rsp.data.allocated, "unallocate left tile allocated")
  `TTRE_ASSERT_IMP(a_quiet_while_clearing, tbl_busy, state == S_IDLE && !rsp.valid && !ctl.wr_en, "activity during clearing pass")

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ttre_pkg::*;

  localparam int unsigned TILE_EDGE      = 64;
  localparam int unsigned TILE_SLOTS     = 4096;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned PRINT_CAP      = 100;
  localparam logic [2:0]  OP_SPARE_LO    = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI    = 3'd7;

  class tile_ledger;
    bit          flag_of [TILE_SLOTS];
    bit [15:0]   count_of [TILE_SLOTS];
    bit [12:0]   width_px;
    bit [12:0]   height_px;
    bit [4:0]    bytes_px;
    bit          auto_on;
    out_word_t   due [$];
    int unsigned fails;

    function new();
      width_px  = IMAGE_WIDTH_RST;
      height_px = IMAGE_HEIGHT_RST;
      bytes_px  = BYTES_PER_PIXEL_RST;
      auto_on   = 1'b0;
      fails     = 0;
    endfunction

    function void report(string msg);
      if (fails < PRINT_CAP) $display("mismatch: %s", msg);
      fails++;
    endfunction

    function void set_reg(cfg_word_t w);
      case (w.reg_index)
        CFG_IMAGE_WIDTH:     width_px  = w.wdata;
        CFG_IMAGE_HEIGHT:    height_px = w.wdata;
        CFG_BYTES_PER_PIXEL: bytes_px  = w.wdata[4:0];
        CFG_AUTO_ALLOC:      auto_on   = w.wdata[0];
        default: ;
      endcase
    endfunction

    function void note_request(in_word_t w);
      out_word_t   r;
      int unsigned px, py, per_row, idx, xoff, yoff, xb, yb, pw, ph;
      r  = '0;
      px = w.pixel_x;
      py = w.pixel_y;
      if (px >= width_px || py >= height_px) begin
        r.status = ST_RANGE;
        due.push_back(r);
        return;
      end
      per_row = (width_px + TILE_EDGE - 1) / TILE_EDGE;
      idx = (py / TILE_EDGE) * per_row + px / TILE_EDGE;
      if (idx >= TILE_SLOTS) begin
        r.status = ST_RANGE;
        due.push_back(r);
        return;
      end
      xoff = px % TILE_EDGE;
      yoff = py % TILE_EDGE;
      xb = px - xoff;
      yb = py - yoff;
      pw = ((TILE_EDGE < width_px - xb) ? TILE_EDGE : width_px - xb) - xoff;
      ph = ((TILE_EDGE < height_px - yb) ? TILE_EDGE : height_px - yb) - yoff;
      r.status = ST_OK;
      case (w.op)
        OP_REF: begin
          if (!flag_of[idx] && auto_on) flag_of[idx] = 1'b1;
          if (flag_of[idx]) begin
            if (count_of[idx] != REFS_MAX) count_of[idx]++;
          end else begin
            r.status = ST_UNALLOC;
          end
        end
        OP_UNREF: begin
          if (count_of[idx] != 0) count_of[idx]--;
          else r.warning = 1'b1;
        end
        OP_ALLOC: flag_of[idx] = 1'b1;
        OP_UNALLOC: begin
          if (flag_of[idx]) begin
            r.warning = (count_of[idx] != 0);
            flag_of[idx] = 1'b0;
          end else begin
            r.status = ST_UNALLOC;
          end
        end
        default: ;
      endcase
      r.tile_index     = 12'(idx);
      r.tile_x_base    = 12'(xb);
      r.tile_y_base    = 12'(yb);
      r.portion_width  = 7'(pw);
      r.portion_height = 7'(ph);
      r.byte_offset    = 16'(bytes_px * (yoff * TILE_EDGE + xoff));
      r.row_stride     = 11'(TILE_EDGE * bytes_px);
      r.allocated      = flag_of[idx];
      r.ref_total      = count_of[idx];
      due.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] got, logic [15:0] want,
                                logic [11:0] tile);
      if (got !== want)
        report($sformatf("%s got %0d expected %0d (tile %0d)", name, got, want, tile));
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (due.size() == 0) begin
        report("result word with nothing outstanding");
        return;
      end
      want = due.pop_front();
      compare_field("status", got.status, want.status, want.tile_index);
      compare_field("warning", got.warning, want.warning, want.tile_index);
      compare_field("tile_index", got.tile_index, want.tile_index, want.tile_index);
      compare_field("tile_x_base", got.tile_x_base, want.tile_x_base, want.tile_index);
      compare_field("tile_y_base", got.tile_y_base, want.tile_y_base, want.tile_index);
      compare_field("portion_width", got.portion_width, want.portion_width, want.tile_index);
      compare_field("portion_height", got.portion_height, want.portion_height,
                    want.tile_index);
      compare_field("byte_offset", got.byte_offset, want.byte_offset, want.tile_index);
      compare_field("row_stride", got.row_stride, want.row_stride, want.tile_index);
      compare_field("allocated", got.allocated, want.allocated, want.tile_index);
      compare_field("ref_total", got.ref_total, want.ref_total, want.tile_index);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  bit          steady;
  int unsigned quiet;
  tile_ledger  board = new();

  ttre_chan_if #(.T(cfg_word_t)) cfg_bus ();
  ttre_chan_if #(.T(in_word_t))  req_bus ();
  ttre_chan_if #(.T(out_word_t)) rsp_bus ();

  tile_table_refcount_engine_core dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) board.set_reg(cfg_bus.data);
      if (rsp_bus.valid && rsp_bus.ready) board.check_result(rsp_bus.data);
      if (req_bus.valid && req_bus.ready) board.note_request(req_bus.data);
      if ((cfg_bus.valid && cfg_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (req_bus.valid && req_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic in_word_t request_of(input logic [2:0] op, input int unsigned x,
                                          input int unsigned y);
    return '{op: op, pixel_x: 12'(x), pixel_y: 12'(y)};
  endfunction

  function automatic int unsigned pick_coord(input int unsigned extent);
    int unsigned lim;
    int unsigned roll;
    lim  = (extent > TILE_SLOTS) ? TILE_SLOTS : extent;
    roll = $urandom_range(0, 99);
    if (lim == 0 || roll < 12) return $urandom_range(0, 4095);
    if (roll < 55) return $urandom_range(0, ((lim < 128) ? lim : 128) - 1);
    if (roll < 65) return lim - 1 - $urandom_range(0, ((lim < 3) ? lim : 3) - 1);
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic logic [2:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return OP_REF;
    if (roll < 58) return OP_UNREF;
    if (roll < 73) return OP_ALLOC;
    if (roll < 85) return OP_UNALLOC;
    if (roll < 94) return OP_QUERY;
    return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  task automatic send_request(input in_word_t w);
    while (!steady && $urandom_range(0, 99) < 22) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= w;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // hold requests until every outstanding result word has been taken
  task automatic settle();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (board.due.size() != 0);
  endtask

  task automatic apply_setup(input int unsigned w, input int unsigned h,
                             input int unsigned bpp, input int unsigned aa);
    cfg_word_t plan [4];
    plan[0] = '{reg_index: CFG_IMAGE_WIDTH,     wdata: 13'(w)};
    plan[1] = '{reg_index: CFG_IMAGE_HEIGHT,    wdata: 13'(h)};
    plan[2] = '{reg_index: CFG_BYTES_PER_PIXEL, wdata: 13'(bpp)};
    plan[3] = '{reg_index: CFG_AUTO_ALLOC,      wdata: 13'(aa)};
    settle();
    foreach (plan[i]) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.data  <= plan[i];
      do @(posedge clk); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic random_burst(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 59) == 0) settle();
      send_request(request_of(pick_op(), pick_coord(board.width_px),
                              pick_coord(board.height_px)));
    end
  endtask

  initial begin
    rst           = 1'b1;
    steady        = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.data  = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(request_of(OP_REF, 0, 0));
    send_request(request_of(OP_UNREF, 0, 0));
    send_request(request_of(OP_UNALLOC, 0, 0));
    send_request(request_of(OP_ALLOC, 4095, 4095));
    send_request(request_of(OP_REF, 4095, 4095));
    send_request(request_of(OP_REF, 4032, 4032));
    send_request(request_of(OP_UNALLOC, 4095, 4095));
    send_request(request_of(OP_REF, 4095, 4095));
    send_request(request_of(OP_UNREF, 4095, 4032));
    send_request(request_of(OP_UNREF, 4032, 4095));
    send_request(request_of(OP_UNREF, 4095, 4095));
    send_request(request_of(OP_QUERY, 4095, 4095));
    send_request(request_of(OP_ALLOC, 63, 4095));
    send_request(request_of(OP_UNALLOC, 63, 4095));
    send_request(request_of(OP_SPARE_LO, 2048, 63));
    send_request(request_of(OP_SPARE_LO + 3'd1, 1365, 2730));
    send_request(request_of(OP_SPARE_HI, 2730, 1365));
    random_burst(100);

    apply_setup(1, 1, 16, 1);
    send_request(request_of(OP_REF, 0, 0));
    send_request(request_of(OP_REF, 1, 0));
    send_request(request_of(OP_REF, 0, 1));
    send_request(request_of(OP_QUERY, 4095, 4095));
    send_request(request_of(OP_UNALLOC, 0, 0));
    send_request(request_of(OP_REF, 0, 0));
    random_burst(30);

    apply_setup(0, 4096, 5, 0);
    random_burst(20);
    apply_setup(4096, 0, 2, 1);
    random_burst(10);
    apply_setup(8191, 8191, 31, 1);
    random_burst(60);
    apply_setup(100, 70, 1, 0);
    random_burst(100);

    apply_setup(4096, 4096, 16, 1);
    steady = 1'b1;
    random_burst(100);
    steady = 1'b0;

    for (int k = 0; k < 4; k++) begin
      apply_setup(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096)
                                               : $urandom_range(1, 300),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096)
                                               : $urandom_range(1, 300),
                  $urandom_range(1, 16), $urandom_range(0, 1));
      random_burst(80);
    end

    // pile references onto one tile and back off it
    apply_setup(4096, 4096, 7, 1);
    steady = 1'b1;
    for (int unsigned i = 0; i < 8; i++)
      send_request(request_of(OP_REF, $urandom_range(64, 127), $urandom_range(192, 255)));
    send_request(request_of(OP_UNREF, 64, 192));
    send_request(request_of(OP_REF, 127, 255));
    send_request(request_of(OP_REF, 100, 200));
    send_request(request_of(OP_UNALLOC, 64, 192));
    send_request(request_of(OP_QUERY, 127, 192));
    steady = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (board.fails == 0 && board.due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
